@@ hdl/cfvg_pkg.sv @@
// Shared constants, types and tables for the circle fan vertex generator.
`timescale 1ns / 1ps
package cfvg_pkg;

  // Field and datapath widths.
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int PHASE_W    = 32;
  localparam int COORD_W    = 32;
  localparam int RADIUS_W   = 31;
  localparam int TEX_W      = 17;
  localparam int TEX_STEPS  = 16;
  localparam int TRIG_W     = 17;
  localparam int XY_W       = 34;
  localparam int Z_W        = 33;
  localparam int PROD_W     = RADIUS_W + 1 + TRIG_W;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int MAX_SEGMENTS_DEF  = 1024;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 32;

  // Fixed-point constants.
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
  localparam logic [TEX_W-1:0] TEX_CENTRE = 17'd32768;
  localparam logic [CNT_W-1:0] RESET_COUNT  = 11'd32;
  localparam logic [RADIUS_W-1:0] RESET_RADIUS = 31'd65536;

  // Truncated arctangent table in Q2.30.
  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_COUNT    = 2'd3
  } reg_addr_t;

  // Quadrant of a turn phase.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // One rim vertex with its texture coordinate.
  typedef struct packed {
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [TEX_W-1:0]          u;
    logic [TEX_W-1:0]          v;
  } rim_t;

endpackage

@@ hdl/cfvg_if.sv @@
// Valid/ready channel interfaces for segment requests and fan results.
`timescale 1ns / 1ps
interface cfvg_in_if;
  import cfvg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] segment_index;
  modport source (output valid, output segment_index, input ready);
  modport sink   (input valid, input segment_index, output ready);
endinterface

interface cfvg_out_if;
  import cfvg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] edge_x;
  logic signed [COORD_W-1:0] edge_y;
  logic signed [COORD_W-1:0] next_edge_x;
  logic signed [COORD_W-1:0] next_edge_y;
  logic [TEX_W-1:0]          tex_u;
  logic [TEX_W-1:0]          tex_v;
  logic [TEX_W-1:0]          next_tex_u;
  logic [TEX_W-1:0]          next_tex_v;
  logic                      index_invalid;
  modport source (output valid, output edge_x, output edge_y, output next_edge_x,
                  output next_edge_y, output tex_u, output tex_v, output next_tex_u,
                  output next_tex_v, output index_invalid, input ready);
  modport sink   (input valid, input edge_x, input edge_y, input next_edge_x,
                  input next_edge_y, input tex_u, input tex_v, input next_tex_u,
                  input next_tex_v, input index_invalid, output ready);
endinterface

@@ hdl/circle_fan_vertex_generator_core.sv @@
// Top level of the circle fan vertex generator: configuration, phase dividers and lanes.
`timescale 1ns / 1ps
// Usage
// A segment index enters on in_if (valid/ready). For each accepted transaction one
// result leaves on out_if: the two rim vertices of that fan segment in Q16.16, their
// Q0.16 texture coordinates and index_invalid. An index at or above the segment count
// returns index_invalid set and every other field zero.
// A result passes from acceptance to out_if.valid through the index registers, the chain of
// 32 phase-division cells, the lane registers, the CORDIC cells, the 16 texture-division
// cells and the output register, all of which advance together. One transaction is taken
// every cycle while the receiver does not hold the pipeline.
// When the receiver holds out_if.ready low with a result waiting, the whole pipeline
// holds and in_if.ready falls; bubbles in the pipeline do not collapse.
// The APB port writes center_x, center_y, circle_radius and segment_count at byte
// addresses 0, 4, 8 and 12; it is to be written only while the block is idle.
// Reset (rst_n low, synchronous) restores the register defaults and empties the
// pipeline; no result is presented until a new transaction has run through.
module circle_fan_vertex_generator_core #(
  parameter int MAX_SEGMENTS  = cfvg_pkg::MAX_SEGMENTS_DEF,
  parameter int CORDIC_STAGES = cfvg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  cfvg_in_if.sink                             in_if,
  cfvg_out_if.source                          out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cfvg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [cfvg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [cfvg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import cfvg_pkg::*;

  localparam int LANE_LAT = CORDIC_STAGES + TEX_STEPS + 4;
  localparam int DEPTH    = 1 + PHASE_W + LANE_LAT;

  typedef struct packed {
    logic valid;
    logic invalid;
  } ctl_t;

  // Configuration registers.
  logic signed [COORD_W-1:0] center_x_r;
  logic signed [COORD_W-1:0] center_y_r;
  logic [RADIUS_W-1:0]       radius_r;
  logic [CNT_W-1:0]          count_r;
  reg_addr_t                 cfg_addr;

  assign cfg_addr = reg_addr_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= RESET_RADIUS;
      count_r    <= RESET_COUNT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_addr)
        REG_CENTER_X: center_x_r <= pwdata;
        REG_CENTER_Y: center_y_r <= pwdata;
        REG_RADIUS:   radius_r   <= pwdata[RADIUS_W-1:0];
        REG_COUNT:    count_r    <= pwdata[CNT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_addr)
      REG_CENTER_X: prdata = center_x_r;
      REG_CENTER_Y: prdata = center_y_r;
      REG_RADIUS:   prdata = {1'b0, radius_r};
      REG_COUNT:    prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, count_r};
      default:      prdata = '0;
    endcase
  end

  // Effective count, index check and the wrapped next index.
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_inc;
  logic             invalid_c;
  logic             en;
  logic             out_valid_r;

  assign count_eff = (int'(count_r) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : count_r;
  assign idx_ext   = CNT_W'(in_if.segment_index);
  assign idx_inc   = idx_ext + CNT_W'(1);
  assign invalid_c = (count_eff == '0) || (idx_ext >= count_eff);

  // The pipeline advances whenever the output register is free or being emptied.
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  logic [CNT_W-1:0] idx_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[0] <= idx_ext;
      idx_r[1] <= (idx_inc >= count_eff) ? '0 : idx_inc;
    end
  end

  // Control bits travel alongside the datapath.
  ctl_t ctl_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= '{valid: in_if.valid, invalid: invalid_c};
      for (int k = 1; k < DEPTH; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // Two lanes: phase division then rim vertex.
  rim_t rim [2];

  for (genvar j = 0; j < 2; j++) begin : g_lane
    logic [CNT_W-1:0]   ph_rem [PHASE_W+1];
    logic [CNT_W-1:0]   ph_div [PHASE_W+1];
    logic [PHASE_W-1:0] ph_num [PHASE_W+1];
    logic [PHASE_W-1:0] ph_quo [PHASE_W+1];

    assign ph_rem[0] = idx_r[j];
    assign ph_div[0] = count_eff;
    assign ph_num[0] = '0;
    assign ph_quo[0] = '0;

    for (genvar k = 0; k < PHASE_W; k++) begin : g_phase
      cfvg_div_cell #(.W(CNT_W), .N(PHASE_W)) u_cell (
        .clk (clk), .en (en),
        .rem_i (ph_rem[k]), .div_i (ph_div[k]), .num_i (ph_num[k]), .quo_i (ph_quo[k]),
        .rem_o (ph_rem[k+1]), .div_o (ph_div[k+1]), .num_o (ph_num[k+1]),
        .quo_o (ph_quo[k+1])
      );
    end

    cfvg_rim_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane (
      .clk        (clk),
      .en         (en),
      .phase_i    (ph_quo[PHASE_W]),
      .center_x_i (center_x_r),
      .center_y_i (center_y_r),
      .radius_i   (radius_r),
      .rim_o      (rim[j])
    );
  end

  // Output register.
  rim_t rim_a_r;
  rim_t rim_b_r;
  logic invalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_r[DEPTH-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      invalid_r <= ctl_r[DEPTH-1].invalid;
      if (ctl_r[DEPTH-1].invalid) begin
        rim_a_r <= '0;
        rim_b_r <= '0;
      end else begin
        rim_a_r <= rim[0];
        rim_b_r <= rim[1];
      end
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.edge_x        = rim_a_r.ex;
  assign out_if.edge_y        = rim_a_r.ey;
  assign out_if.next_edge_x   = rim_b_r.ex;
  assign out_if.next_edge_y   = rim_b_r.ey;
  assign out_if.tex_u         = rim_a_r.u;
  assign out_if.tex_v         = rim_a_r.v;
  assign out_if.next_tex_u    = rim_b_r.u;
  assign out_if.next_tex_v    = rim_b_r.v;
  assign out_if.index_invalid = invalid_r;

  // A flagged index carries all-zero geometry.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && invalid_r |->
      (rim_a_r == '0) && (rim_b_r == '0))
    else $error("flagged result carries non-zero geometry");

  // The dominant axis always projects onto an edge of the unit square.
  a_tex_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !invalid_r |->
      (rim_a_r.u == '0) || (rim_a_r.u == 17'd65536) ||
      (rim_a_r.v == '0) || (rim_a_r.v == 17'd65536))
    else $error("texture coordinate not on the square edge");

  // The next-vertex texture coordinates stay within Q0.16 from 0 to 1.
  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rim_b_r.u <= 17'd65536) && (rim_b_r.v <= 17'd65536))
    else $error("texture coordinate out of range");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result presented straight after reset");
endmodule

@@ hdl/cfvg_div_cell.sv @@
// One restoring-division cell: one quotient bit per cycle while en is high, handed to the next cell.
`timescale 1ns / 1ps
module cfvg_div_cell #(
  parameter int W = 17,
  parameter int N = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] div_i,
  input  logic [N-1:0] num_i,
  input  logic [N-1:0] quo_i,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] div_o,
  output logic [N-1:0] num_o,
  output logic [N-1:0] quo_o
);
  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] rem_r;
  logic [W-1:0] div_r;
  logic [N-1:0] num_r;
  logic [N-1:0] quo_r;

  // Bring in the next numerator bit and subtract the divisor where it fits.
  assign trial   = {rem_i, num_i[N-1]};
  assign ge      = (trial >= {1'b0, div_i});
  assign rem_nxt = ge ? W'(trial - {1'b0, div_i}) : W'(trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= div_i;
      num_r <= {num_i[N-2:0], 1'b0};
      quo_r <= {quo_i[N-2:0], ge};
    end
  end

  assign rem_o = rem_r;
  assign div_o = div_r;
  assign num_o = num_r;
  assign quo_o = quo_r;
endmodule

@@ hdl/cfvg_cordic_cell.sv @@
// One CORDIC rotation cell with a fixed shift and arctangent.
`timescale 1ns / 1ps
module cfvg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [cfvg_pkg::XY_W-1:0]   x_i,
  input  logic signed [cfvg_pkg::XY_W-1:0]   y_i,
  input  logic signed [cfvg_pkg::Z_W-1:0]    z_i,
  input  cfvg_pkg::quad_t                    q_i,
  output logic signed [cfvg_pkg::XY_W-1:0]   x_o,
  output logic signed [cfvg_pkg::XY_W-1:0]   y_o,
  output logic signed [cfvg_pkg::Z_W-1:0]    z_o,
  output cfvg_pkg::quad_t                    q_o
);
  import cfvg_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = $signed({1'b0, ATAN_TABLE[STAGE]});

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [XY_W-1:0] x_r;
  logic signed [XY_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;
  quad_t                  q_r;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  // Rotate towards zero residual angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - ATAN;
      end else begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + ATAN;
      end
      q_r <= q_i;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign q_o = q_r;
endmodule

@@ hdl/cfvg_rim_lane.sv @@
// One rim vertex lane: phase to sine/cosine, vertex placement and texture projection.
`timescale 1ns / 1ps
module cfvg_rim_lane #(
  parameter int CORDIC_STAGES = cfvg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [cfvg_pkg::PHASE_W-1:0]         phase_i,
  input  logic signed [cfvg_pkg::COORD_W-1:0]  center_x_i,
  input  logic signed [cfvg_pkg::COORD_W-1:0]  center_y_i,
  input  logic [cfvg_pkg::RADIUS_W-1:0]        radius_i,
  output cfvg_pkg::rim_t                       rim_o
);
  import cfvg_pkg::*;

  localparam int NS = CORDIC_STAGES;

  typedef struct packed {
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      neg_c;
    logic                      neg_s;
    logic                      m_zero;
  } vtx_t;

  // Round half up to Q1.15 and saturate.
  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [XY_W-1:0] a);
    logic signed [XY_W-1:0] t;
    t = (a + XY_W'(16384)) >>> 15;
    if (t > XY_W'(32767)) begin
      return TRIG_W'(32767);
    end else if (t < -XY_W'(32768)) begin
      return -TRIG_W'(32768);
    end
    return TRIG_W'(t);
  endfunction

  // Centre plus rounded radius product, saturated to 32 bits.
  function automatic logic signed [COORD_W-1:0] place(
    input logic signed [COORD_W-1:0] center,
    input logic signed [PROD_W-1:0]  prod
  );
    logic signed [PROD_W-1:0] sh;
    logic signed [PROD_W:0]   sum;
    sh  = (prod + PROD_W'(16384)) >>> 15;
    sum = (PROD_W+1)'(center) + (PROD_W+1)'(sh);
    if (sum > (PROD_W+1)'(2147483647)) begin
      return 32'sh7FFFFFFF;
    end else if (sum < -(PROD_W+1)'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return COORD_W'(sum);
  endfunction

  // Quarter-turn residual scaled to radians.
  logic [60:0]             zprod;
  logic signed [Z_W-1:0]   z0_r;
  quad_t                   quad0_r;

  assign zprod = {31'b0, phase_i[29:0]} * {30'b0, HALF_PI_Q30};

  always_ff @(posedge clk) begin
    if (en) begin
      z0_r    <= $signed({2'b00, zprod[60:30]});
      quad0_r <= quad_t'(phase_i[31:30]);
    end
  end

  // CORDIC cell chain.
  logic signed [XY_W-1:0] cx [NS+1];
  logic signed [XY_W-1:0] cy [NS+1];
  logic signed [Z_W-1:0]  cz [NS+1];
  quad_t                  cq [NS+1];

  assign cx[0] = $signed({2'b00, CORDIC_GAIN_Q30});
  assign cy[0] = '0;
  assign cz[0] = z0_r;
  assign cq[0] = quad0_r;

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    cfvg_cordic_cell #(.STAGE(k)) u_cell (
      .clk (clk), .en (en),
      .x_i (cx[k]), .y_i (cy[k]), .z_i (cz[k]), .q_i (cq[k]),
      .x_o (cx[k+1]), .y_o (cy[k+1]), .z_o (cz[k+1]), .q_o (cq[k+1])
    );
  end

  // Round and rotate into the quadrant.
  logic signed [TRIG_W-1:0] xq;
  logic signed [TRIG_W-1:0] yq;
  logic signed [TRIG_W-1:0] c_nxt;
  logic signed [TRIG_W-1:0] s_nxt;
  logic signed [TRIG_W-1:0] c_r;
  logic signed [TRIG_W-1:0] s_r;

  assign xq = to_q15(cx[NS]);
  assign yq = to_q15(cy[NS]);

  always_comb begin
    case (cq[NS])
      QUAD_0:  begin c_nxt = xq;  s_nxt = yq;  end
      QUAD_1:  begin c_nxt = -yq; s_nxt = xq;  end
      QUAD_2:  begin c_nxt = -xq; s_nxt = -yq; end
      QUAD_3:  begin c_nxt = yq;  s_nxt = -xq; end
      default: begin c_nxt = xq;  s_nxt = yq;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
    end
  end

  // Radius products, magnitudes and the texture divisor.
  logic [TEX_W-1:0]          mag_c;
  logic [TEX_W-1:0]          mag_s;
  logic signed [PROD_W-1:0]  prod_x_r;
  logic signed [PROD_W-1:0]  prod_y_r;
  logic [TEX_W-1:0]          mag_c_r;
  logic [TEX_W-1:0]          mag_s_r;
  logic [TEX_STEPS-1:0]      m_r;
  logic                      neg_c_r;
  logic                      neg_s_r;
  logic                      m_zero_r;

  assign mag_c = (c_r < 0) ? TEX_W'(-c_r) : TEX_W'(c_r);
  assign mag_s = (s_r < 0) ? TEX_W'(-s_r) : TEX_W'(s_r);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= PROD_W'($signed({1'b0, radius_i})) * PROD_W'(c_r);
      prod_y_r <= PROD_W'($signed({1'b0, radius_i})) * PROD_W'(s_r);
      mag_c_r  <= mag_c;
      mag_s_r  <= mag_s;
      m_r      <= (mag_s > mag_c) ? TEX_STEPS'(mag_s) : TEX_STEPS'(mag_c);
      m_zero_r <= (mag_c == '0) && (mag_s == '0);
      neg_c_r  <= (c_r < 0);
      neg_s_r  <= (s_r < 0);
    end
  end

  // Vertex sums wait here while the texture dividers run.
  vtx_t vtx_r [TEX_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      vtx_r[0] <= '{ex: place(center_x_i, prod_x_r), ey: place(center_y_i, prod_y_r),
                    neg_c: neg_c_r, neg_s: neg_s_r, m_zero: m_zero_r};
      for (int k = 1; k < TEX_STEPS; k++) begin
        vtx_r[k] <= vtx_r[k-1];
      end
    end
  end

  // Texture dividers: (mag * 65536 + m) / (2 * m), one quotient bit per cell.
  logic [TEX_W-1:0]     du_rem [TEX_STEPS+1];
  logic [TEX_W-1:0]     du_div [TEX_STEPS+1];
  logic [TEX_STEPS-1:0] du_num [TEX_STEPS+1];
  logic [TEX_STEPS-1:0] du_quo [TEX_STEPS+1];
  logic [TEX_W-1:0]     dv_rem [TEX_STEPS+1];
  logic [TEX_W-1:0]     dv_div [TEX_STEPS+1];
  logic [TEX_STEPS-1:0] dv_num [TEX_STEPS+1];
  logic [TEX_STEPS-1:0] dv_quo [TEX_STEPS+1];

  assign du_rem[0] = mag_c_r;
  assign du_div[0] = {m_r, 1'b0};
  assign du_num[0] = m_r;
  assign du_quo[0] = '0;
  assign dv_rem[0] = mag_s_r;
  assign dv_div[0] = {m_r, 1'b0};
  assign dv_num[0] = m_r;
  assign dv_quo[0] = '0;

  for (genvar k = 0; k < TEX_STEPS; k++) begin : g_tex
    cfvg_div_cell #(.W(TEX_W), .N(TEX_STEPS)) u_du (
      .clk (clk), .en (en),
      .rem_i (du_rem[k]), .div_i (du_div[k]), .num_i (du_num[k]), .quo_i (du_quo[k]),
      .rem_o (du_rem[k+1]), .div_o (du_div[k+1]), .num_o (du_num[k+1]),
      .quo_o (du_quo[k+1])
    );
    cfvg_div_cell #(.W(TEX_W), .N(TEX_STEPS)) u_dv (
      .clk (clk), .en (en),
      .rem_i (dv_rem[k]), .div_i (dv_div[k]), .num_i (dv_num[k]), .quo_i (dv_quo[k]),
      .rem_o (dv_rem[k+1]), .div_o (dv_div[k+1]), .num_o (dv_num[k+1]),
      .quo_o (dv_quo[k+1])
    );
  end

  // Map to Q0.16 around the centre, with v flipped.
  logic [TEX_W-1:0] tu;
  logic [TEX_W-1:0] tv;
  vtx_t             vtx_end;
  rim_t             rim_r;

  assign tu      = TEX_W'(du_quo[TEX_STEPS]);
  assign tv      = TEX_W'(dv_quo[TEX_STEPS]);
  assign vtx_end = vtx_r[TEX_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      rim_r.ex <= vtx_end.ex;
      rim_r.ey <= vtx_end.ey;
      if (vtx_end.m_zero) begin
        rim_r.u <= TEX_CENTRE;
        rim_r.v <= TEX_CENTRE;
      end else begin
        rim_r.u <= vtx_end.neg_c ? TEX_CENTRE - tu : TEX_CENTRE + tu;
        rim_r.v <= vtx_end.neg_s ? TEX_CENTRE + tv : TEX_CENTRE - tv;
      end
    end
  end

  assign rim_o = rim_r;
endmodule
